// ----- hdl/rtof_pkg.sv -----
// ----------------------------------------------------------------------------
// rtof_pkg: shared types and constants of the root tuple obstruction filter
// Widths of roots, symmetric sums and the modular accumulator.
// ----------------------------------------------------------------------------
package rtof_pkg;

	localparam int ROOT_W       = 9;
	localparam int N_ROOTS      = 5;
	localparam int DIAM_LIMIT   = 511;
	// s5 of five 9-bit roots stays below 2^46
	localparam int SUM_W        = 46;
	// s1 < 2^12, s2 < 2^22, s3 < 2^31
	localparam int S1_W         = 12;
	localparam int S2_W         = 22;
	localparam int S3_W         = 31;
	// obstruction value is formed modulo 2^64
	localparam int ACC_W        = 64;
	localparam int SHIFT_W      = 4;
	localparam int IDX_W        = 3;

	typedef logic [ROOT_W-1:0] root_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic busy;
		logic is_one;
	} gcd_stat_t;

	typedef struct packed {
		logic busy;
		logic zero;
	} poly_stat_t;

endpackage

// ----- hdl/rtof_tuple_if.sv -----
// ----------------------------------------------------------------------------
// rtof_tuple_if: request channel carrying one root tuple
// Valid/ready handshake with the five roots as payload.
// ----------------------------------------------------------------------------
interface rtof_tuple_if
	import rtof_pkg::*;
	();
	logic  valid;
	logic  ready;
	root_t root_a;
	root_t root_b;
	root_t root_c;
	root_t root_d;
	root_t root_e;

	modport source (output valid, root_a, root_b, root_c, root_d, root_e, input ready);
	modport sink   (input valid, root_a, root_b, root_c, root_d, root_e, output ready);
endinterface

// ----- hdl/rtof_verdict_if.sv -----
// ----------------------------------------------------------------------------
// rtof_verdict_if: result channel carrying the five classification flags
// Valid/ready handshake with one flag set per request.
// ----------------------------------------------------------------------------
interface rtof_verdict_if;
	logic valid;
	logic ready;
	logic well_ordered;
	logic gcd_is_one;
	logic lex_normalized;
	logic obstruction_zero;
	logic mirror_symmetric;

	modport source (output valid, well_ordered, gcd_is_one, lex_normalized,
		obstruction_zero, mirror_symmetric, input ready);
	modport sink   (input valid, well_ordered, gcd_is_one, lex_normalized,
		obstruction_zero, mirror_symmetric, output ready);
endinterface

// ----- hdl/root_tuple_obstruction_filter.sv -----
// ----------------------------------------------------------------------------
// root_tuple_obstruction_filter: classifier for tuples (0,a,b,c,d,e)
// Order, gcd, lex normal form, obstruction polynomial and mirror flags.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                   handshake
//  tuple     in    root_a..root_e, 9 bits each               valid/ready
//  verdict   out   well_ordered, gcd_is_one, lex_normalized,  valid/ready
//                  obstruction_zero, mirror_symmetric
//
// One request is worked at a time: accept, the chain of sum cells, the
// polynomial evaluation, then the load of the output register. The binary
// gcd loop runs alongside, and the load waits for it when it runs longer.
// The next request is accepted only after the verdict loads.
// arst_n clears all control state; no clearing pass is needed.
// A stalled verdict holds in the output register while the next request
// is accepted and worked; the engine waits only to hand over a result.
// ----------------------------------------------------------------------------
module root_tuple_obstruction_filter
	import rtof_pkg::*;
	(
	input  logic clk,
	input  logic arst_n,
	rtof_tuple_if.sink     tuple,
	rtof_verdict_if.source verdict
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUM  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] cnt_q;

	logic       accept;
	logic       load_out;
	root_t      roots_in [N_ROOTS];
	root_t      line_q   [N_ROOTS];
	sum_t       sums     [N_ROOTS];
	sum_t       lefts    [N_ROOTS];
	logic       cell_step;
	logic       poly_start;
	gcd_stat_t  gcd_st;
	poly_stat_t poly_st;

	// flags that come straight from the request
	logic                     ordered_d, lex_d, mirror_d;
	logic                     ordered_q, lex_q, mirror_q;
	logic signed [ROOT_W:0]   fa, fb, fc, fd, fe;

	logic out_valid_q;
	logic out_ordered_q, out_gcd_q, out_lex_q, out_obs_q, out_mirror_q;

	assign roots_in[0] = tuple.root_a;
	assign roots_in[1] = tuple.root_b;
	assign roots_in[2] = tuple.root_c;
	assign roots_in[3] = tuple.root_d;
	assign roots_in[4] = tuple.root_e;

	assign tuple.ready = (state_q == S_IDLE);
	assign accept      = tuple.valid && tuple.ready;

	assign fa = signed'({1'b0, tuple.root_a});
	assign fb = signed'({1'b0, tuple.root_b});
	assign fc = signed'({1'b0, tuple.root_c});
	assign fd = signed'({1'b0, tuple.root_d});
	assign fe = signed'({1'b0, tuple.root_e});

	always_comb begin
		ordered_d = (tuple.root_a != '0) && (tuple.root_a < tuple.root_b)
			&& (tuple.root_b < tuple.root_c) && (tuple.root_c < tuple.root_d)
			&& (tuple.root_d < tuple.root_e)
			&& ({1'b0, tuple.root_e} <= (ROOT_W + 1)'(DIAM_LIMIT));
		mirror_d  = ((fa + fd) == fe) && ((fb + fc) == fe);
		// first differing entry against the reflection decides
		priority if (fa != fe - fd) begin
			lex_d = fa < fe - fd;
		end else if (fb != fe - fc) begin
			lex_d = fb < fe - fc;
		end else if (fc != fe - fb) begin
			lex_d = fc < fe - fb;
		end else if (fd != fe - fa) begin
			lex_d = fd < fe - fa;
		end else begin
			lex_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ordered_q <= ordered_d;
			lex_q     <= lex_d;
			mirror_q  <= mirror_d;
		end
	end

	// root line: load on accept, advance one root per cycle into the cells
	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= roots_in;
		end else if (cell_step) begin
			for (int i = 0; i < N_ROOTS - 1; i++) begin
				line_q[i] <= line_q[i + 1];
			end
		end
	end

	assign cell_step  = (state_q == S_SUM);
	assign poly_start = cell_step && (cnt_q == IDX_W'(N_ROOTS - 1));

	for (genvar j = 0; j < N_ROOTS; j++) begin : g_cells
		if (j == 0) begin : g_head
			assign lefts[j] = SUM_W'(1);
		end else begin : g_body
			assign lefts[j] = sums[j - 1];
		end
		rtof_cell u_cell (
			.clk  (clk),
			.clr  (accept),
			.step (cell_step),
			.root (line_q[0]),
			.left (lefts[j]),
			.s    (sums[j])
		);
	end

	rtof_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.roots  (roots_in),
		.stat   (gcd_st)
	);

	rtof_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (poly_start),
		.sums   (sums),
		.stat   (poly_st)
	);

	// hand over when both units are done and the output slot is free
	assign load_out = (state_q == S_WAIT) && !poly_st.busy && !gcd_st.busy
		&& (!out_valid_q || verdict.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SUM;
						cnt_q   <= '0;
					end
				end
				S_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (poly_start) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ordered_q <= ordered_q;
			out_gcd_q     <= gcd_st.is_one;
			out_lex_q     <= lex_q;
			out_obs_q     <= poly_st.zero;
			out_mirror_q  <= mirror_q;
		end
	end

	assign verdict.valid            = out_valid_q;
	assign verdict.well_ordered     = out_ordered_q;
	assign verdict.gcd_is_one       = out_gcd_q;
	assign verdict.lex_normalized   = out_lex_q;
	assign verdict.obstruction_zero = out_obs_q;
	assign verdict.mirror_symmetric = out_mirror_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !tuple.ready)
		else $error("request accepted while engine busy");

	a_gcd_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_st.busy |-> state_q != S_IDLE)
		else $error("gcd loop running with engine idle");

	a_poly_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		poly_st.busy |-> state_q == S_WAIT)
		else $error("polynomial unit busy outside wait state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !verdict.ready |-> !load_out)
		else $error("stalled verdict overwritten");

endmodule

// ----- hdl/rtof_cell.sv -----
// ----------------------------------------------------------------------------
// rtof_cell: one elementary symmetric sum cell
// Holds s_k and folds in one root per step from its left neighbor's s_(k-1).
// ----------------------------------------------------------------------------
module rtof_cell
	import rtof_pkg::*;
	(
	input  logic  clk,
	input  logic  clr,
	input  logic  step,
	input  root_t root,
	input  sum_t  left,
	output sum_t  s
);
	sum_t s_q;

	always_ff @(posedge clk) begin
		if (clr) begin
			s_q <= '0;
		end else if (step) begin
			s_q <= s_q + SUM_W'(left * root);
		end
	end

	assign s = s_q;
endmodule

// ----- hdl/rtof_gcd.sv -----
// ----------------------------------------------------------------------------
// rtof_gcd: binary gcd fold over the five roots
// One halving or subtract-and-halve step per cycle; reports gcd == 1.
// ----------------------------------------------------------------------------
module rtof_gcd
	import rtof_pkg::*;
	(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  root_t     roots [N_ROOTS],
	output gcd_stat_t stat
);
	logic                busy_q;
	logic                is_one_q;
	logic [IDX_W-1:0]    idx_q;
	root_t               x_q;
	root_t               y_q;
	logic [SHIFT_W-1:0]  k_q;
	root_t               roots_q [N_ROOTS];
	root_t               g_w;

	// one operand is zero here, so the OR is the other one
	assign g_w = ROOT_W'((x_q | y_q) << k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (x_q == '0 || y_q == '0) && idx_q == IDX_W'(N_ROOTS - 1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			roots_q  <= roots;
			x_q      <= '0;
			y_q      <= roots[0];
			k_q      <= '0;
			idx_q    <= '0;
		end else if (busy_q) begin
			priority if (x_q == '0 || y_q == '0) begin
				if (idx_q == IDX_W'(N_ROOTS - 1)) begin
					is_one_q <= (g_w == ROOT_W'(1));
				end else begin
					idx_q <= idx_q + 1'b1;
					x_q   <= g_w;
					y_q   <= roots_q[idx_q + 1'b1];
					k_q   <= '0;
				end
			end else if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
	end

	assign stat.busy   = busy_q;
	assign stat.is_one = is_one_q;
endmodule

// ----- hdl/rtof_poly.sv -----
// ----------------------------------------------------------------------------
// rtof_poly: obstruction polynomial evaluator
// Horner form in s1 with side products formed alongside, modulo 2^64, then a zero test.
// ----------------------------------------------------------------------------
module rtof_poly
	import rtof_pkg::*;
	(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  sum_t       sums [N_ROOTS],
	output poly_stat_t stat
);
	logic             busy_q;
	logic [IDX_W-1:0] step_q;
	acc_t             acc_q;
	acc_t             sq_q;
	acc_t             s2sq_q;
	acc_t             s2s3_q;
	logic             zero_q;

	logic [S1_W-1:0]  s1;
	logic [S2_W-1:0]  s2;
	logic [S3_W-1:0]  s3;
	acc_t             s4;
	acc_t             s5;

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(5);

	assign s1 = S1_W'(sums[0]);
	assign s2 = S2_W'(sums[1]);
	assign s3 = S3_W'(sums[2]);
	assign s4 = ACC_W'(sums[3]);
	assign s5 = ACC_W'(sums[4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			unique case (step_q)
				3'd0: sq_q <= ACC_W'(s1) * ACC_W'(s1);
				3'd1: begin
					acc_q  <= ACC_W'(6) * ACC_W'(s2) - sq_q;
					s2sq_q <= ACC_W'(s2) * ACC_W'(s2);
				end
				3'd2: begin
					acc_q  <= acc_q * ACC_W'(s1) - ACC_W'(7) * ACC_W'(s3);
					s2s3_q <= ACC_W'(s2) * ACC_W'(s3);
				end
				3'd3: acc_q <= acc_q * ACC_W'(s1) - (s2sq_q << 3) + (s4 << 3);
				3'd4: acc_q <= acc_q * ACC_W'(s1) + ACC_W'(12) * s2s3_q
					- ACC_W'(24) * s5;
				default: zero_q <= (acc_q == '0);
			endcase
		end
	end

	assign stat.busy = busy_q;
	assign stat.zero = zero_q;
endmodule

// ----- tb/sv/tb_rtof_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtof_channels: testbench-side types used by the filter testbench
// The block's interfaces come from the RTL; this file only groups the
// testbench-side types shared between processes.
// ----------------------------------------------------------------------------
package tb_rtof_types;
	import rtof_pkg::*;

	typedef struct packed {
		root_t a;
		root_t b;
		root_t c;
		root_t d;
		root_t e;
	} tuple_t;

	typedef struct packed {
		logic well_ordered;
		logic gcd_is_one;
		logic lex_normalized;
		logic obstruction_zero;
		logic mirror_symmetric;
	} verdict_t;
endpackage

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for root_tuple_obstruction_filter
// Drives root tuples over the request channel, predicts the five flags of
// each tuple and compares every verdict in order, under several idle and
// stall patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
	import rtof_pkg::*;
	import tb_rtof_types::*;

	logic clk;
	logic arst_n;

	rtof_tuple_if   tuple ();
	rtof_verdict_if verdict ();

	root_tuple_obstruction_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tuple   (tuple),
		.verdict (verdict)
	);

	// flags awaiting their verdict, oldest first
	verdict_t pending_flags[$];
	int       error_count;
	int       send_idle_pct;
	int       recv_stall_pct;
	bit       recv_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop: generous bound over the slowest correct run
	initial begin
		#20_000_000;
		$display("root_tuple_obstruction_filter verification failed");
		$finish;
	end

	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// classify one tuple, flags as the block should produce them
	function automatic verdict_t classify_tuple(tuple_t t);
		verdict_t        v;
		longint unsigned r[5];
		longint unsigned s[6];
		longint unsigned g, p;
		int              full[6], refl[6];
		r[0] = t.a; r[1] = t.b; r[2] = t.c; r[3] = t.d; r[4] = t.e;
		v.well_ordered = (r[0] > 0) && (r[0] < r[1]) && (r[1] < r[2]) &&
			(r[2] < r[3]) && (r[3] < r[4]) && (r[4] <= DIAM_LIMIT);
		g = 0;
		for (int i = 0; i < 5; i++) g = gcd_of(g, r[i]);
		v.gcd_is_one = (g == 1);
		full[0] = 0;
		for (int i = 0; i < 5; i++) full[i+1] = int'(r[i]);
		for (int i = 0; i < 6; i++) refl[i] = full[5] - full[5-i];
		v.lex_normalized = 1'b1;
		for (int i = 0; i < 6; i++) begin
			if (full[i] != refl[i]) begin
				v.lex_normalized = full[i] < refl[i];
				break;
			end
		end
		s = '{1, 0, 0, 0, 0, 0};
		for (int i = 0; i < 5; i++)
			for (int k = 5; k >= 1; k--) s[k] += r[i] * s[k-1];
		// wraps modulo 2^64 like the block's accumulator
		p = 0;
		p -= s[1]*s[1]*s[1]*s[1]*s[1];
		p += 6*s[1]*s[1]*s[1]*s[2];
		p -= 7*s[1]*s[1]*s[3];
		p -= 8*s[1]*s[2]*s[2];
		p += 8*s[1]*s[4];
		p += 12*s[2]*s[3];
		p -= 24*s[5];
		v.obstruction_zero = (p == 0);
		v.mirror_symmetric = (r[0] + r[3] == r[4]) && (r[1] + r[2] == r[4]);
		return v;
	endfunction

	task automatic report_mismatch(string what, logic got, logic want);
		error_count++;
		$display("[%0t] mismatch %s: got %0b want %0b", $time, what, got, want);
	endtask

	// offer one request and hold it until accepted; drop valid while idling
	task automatic send_tuple(tuple_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			tuple.valid <= 1'b0;
			@(negedge clk);
		end
		tuple.valid  <= 1'b1;
		tuple.root_a <= t.a;
		tuple.root_b <= t.b;
		tuple.root_c <= t.c;
		tuple.root_d <= t.d;
		tuple.root_e <= t.e;
		do @(posedge clk); while (!tuple.ready);
		pending_flags.push_back(classify_tuple(t));
		@(negedge clk);
	endtask

	// drive ready on the falling edge; hold it low during a hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			verdict.ready <= 1'b0;
		end else begin
			verdict.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// check each verdict against the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && verdict.valid && verdict.ready) begin
			if (pending_flags.size() == 0) begin
				error_count++;
				$display("[%0t] verdict with no request outstanding", $time);
			end else begin
				want = pending_flags.pop_front();
				if (verdict.well_ordered !== want.well_ordered)
					report_mismatch("well_ordered", verdict.well_ordered, want.well_ordered);
				if (verdict.gcd_is_one !== want.gcd_is_one)
					report_mismatch("gcd_is_one", verdict.gcd_is_one, want.gcd_is_one);
				if (verdict.lex_normalized !== want.lex_normalized)
					report_mismatch("lex_normalized", verdict.lex_normalized,
						want.lex_normalized);
				if (verdict.obstruction_zero !== want.obstruction_zero)
					report_mismatch("obstruction_zero", verdict.obstruction_zero,
						want.obstruction_zero);
				if (verdict.mirror_symmetric !== want.mirror_symmetric)
					report_mismatch("mirror_symmetric", verdict.mirror_symmetric,
						want.mirror_symmetric);
			end
		end
	end

	function automatic tuple_t make_tuple(int a, int b, int c, int d, int e);
		tuple_t t;
		t.a = root_t'(a); t.b = root_t'(b); t.c = root_t'(c);
		t.d = root_t'(d); t.e = root_t'(e);
		return t;
	endfunction

	// random ordered tuple, often scaled by a common factor or mirrored
	function automatic tuple_t random_ordered(int max_e);
		int     v[5];
		int     w[4];
		int     e, k;
		tuple_t t;
		e = $urandom_range(max_e, 5);
		do begin
			for (int i = 0; i < 4; i++) w[i] = $urandom_range(e - 1, 1);
			w.sort();
		end while (w[0] == w[1] || w[1] == w[2] || w[2] == w[3]);
		for (int i = 0; i < 4; i++) v[i] = w[i];
		v[4] = e;
		if ($urandom_range(3) == 0) begin
			// mirror about e/2
			v[3] = e - v[0];
			v[2] = e - v[1];
		end
		if ($urandom_range(3) == 0) begin
			k = $urandom_range(4, 2);
			for (int i = 0; i < 5; i++) v[i] = (v[i] * k) % 512;
		end
		t = make_tuple(v[0], v[1], v[2], v[3], v[4]);
		return t;
	endfunction

	// drop the request and wait for every outstanding verdict
	task automatic wait_drained();
		tuple.valid <= 1'b0;
		while (pending_flags.size() != 0) @(negedge clk);
	endtask

	// field extremes, zero tuple, negative reflections, mirror, gcd cases
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_tuple(make_tuple(0, 0, 0, 0, 0));
		send_tuple(make_tuple(511, 511, 511, 511, 511));
		send_tuple(make_tuple(1, 2, 3, 4, 5));
		send_tuple(make_tuple(1, 2, 3, 4, 511));
		send_tuple(make_tuple(507, 508, 509, 510, 511));
		send_tuple(make_tuple(2, 4, 6, 8, 10));
		send_tuple(make_tuple(1, 3, 4, 6, 7));
		send_tuple(make_tuple(1, 2, 5, 6, 7));
		send_tuple(make_tuple(3, 2, 1, 4, 5));
		send_tuple(make_tuple(100, 50, 0, 511, 1));
		send_tuple(make_tuple(0, 1, 2, 3, 4));
		send_tuple(make_tuple(511, 0, 0, 0, 0));
		send_tuple(make_tuple(0, 0, 0, 0, 511));
		send_tuple(make_tuple(1, 1, 1, 1, 1));
		send_tuple(make_tuple(4, 8, 12, 16, 20));
		send_tuple(make_tuple(1, 170, 341, 510, 511));
		send_tuple(make_tuple(256, 128, 64, 32, 16));
		send_tuple(make_tuple(1, 4, 6, 9, 10));
		send_tuple(make_tuple(2, 3, 7, 8, 10));
		send_tuple(make_tuple(255, 256, 257, 258, 510));
		wait_drained();
	endtask

	// random mix: mostly ordered tuples, some raw noise
	task automatic test_random(int count, int idle, int stall);
		tuple_t t;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) < 7)
				t = random_ordered(($urandom_range(7) == 0) ? 511 : 40);
			else
				t = make_tuple($urandom_range(511), $urandom_range(511),
					$urandom_range(511), $urandom_range(511), $urandom_range(511));
			send_tuple(t);
		end
	endtask

	// hold off the output long enough for the block to fill and stall input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				recv_hold = 1'b1;
				repeat (600) @(negedge clk);
				recv_hold = 1'b0;
			end
			begin
				for (int n = 0; n < 6; n++) send_tuple(random_ordered(40));
			end
		join
		// pause the sender until every verdict is back
		wait_drained();
		for (int n = 0; n < 20; n++) send_tuple(random_ordered(511));
	endtask

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b0;
		arst_n = 1'b0;
		tuple.valid  = 1'b0;
		tuple.root_a = '0;
		tuple.root_b = '0;
		tuple.root_c = '0;
		tuple.root_d = '0;
		tuple.root_e = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(200, 0, 0);
		test_random(200, 80, 0);
		test_random(200, 0, 80);
		test_random(180, 16, 16);
		test_backpressure();

		// drain, then allow the block's worst latency to pass
		wait_drained();
		repeat (200) @(negedge clk);
		if (error_count == 0 && pending_flags.size() == 0) begin
			$display("root_tuple_obstruction_filter verification clean");
		end else begin
			$display("root_tuple_obstruction_filter verification failed");
		end
		$finish;
	end
endmodule

// ----- files.f -----
hdl/rtof_pkg.sv
hdl/rtof_tuple_if.sv
hdl/rtof_verdict_if.sv
hdl/rtof_cell.sv
hdl/rtof_gcd.sv
hdl/rtof_poly.sv
hdl/root_tuple_obstruction_filter.sv
tb/sv/tb_rtof_channels.sv
tb/sv/tb.sv
